[design/ttc_pkg.sv]
// Shared types and constants for the text encoding transcoder.
// No dependencies; imported by every design module but the checker.
package ttc_pkg;

  typedef enum logic [1:0] {
    ENC_BYTE  = 2'd0,
    ENC_UTF8  = 2'd1,
    ENC_UTF16 = 2'd2,
    ENC_UTF32 = 2'd3
  } enc_t;

  typedef enum logic [1:0] {
    JOB_PASS  = 2'd0,
    JOB_ENC   = 2'd1,
    JOB_TRUNC = 2'd2
  } job_kind_t;

  typedef struct packed {
    logic [31:0] unit;
    job_kind_t   kind;
    logic        last;
  } job_t;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DST = 1'd1;

  localparam enc_t SRC_RESET = ENC_UTF8;
  localparam enc_t DST_RESET = ENC_UTF16;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] SUBST_CHAR  = 32'h0000_003F;
  localparam logic [31:0] SUPP_BASE   = 32'h0001_0000;
  localparam logic [15:0] SURR_MASK   = 16'hFC00;
  localparam logic [15:0] SURR_HIGH   = 16'hD800;
  localparam logic [15:0] SURR_LOW    = 16'hDC00;

endpackage

[design/ttc_front.sv]
// Front end: accepts source units, tracks the partial code point and
// classifies each word into a job for the queue. Depends on ttc_pkg.
module ttc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  ttc_pkg::enc_t src_enc,
  input  ttc_pkg::enc_t dst_enc,
  input  logic          in_valid,
  input  logic [31:0]   in_unit,
  input  logic          in_last,
  input  logic          q_ready,
  output logic          push_valid,
  output ttc_pkg::job_t push_job
);
  import ttc_pkg::*;

  logic [20:0] partial_r, partial_nxt;
  logic [1:0]  pending_r, pending_nxt;
  logic [31:0] cp;
  logic [20:0] cont8;
  logic [20:0] pair16;
  logic        have;
  logic        emit;
  logic        acc;

  assign acc    = in_valid & q_ready;
  assign cont8  = {partial_r[14:0], in_unit[5:0]};
  assign pair16 = {1'b0, partial_r[9:0], in_unit[9:0]} + SUPP_BASE[20:0];

  always_comb begin
    partial_nxt   = partial_r;
    pending_nxt   = pending_r;
    cp            = '0;
    have          = 1'b0;
    emit          = 1'b0;
    push_job.unit = '0;
    push_job.kind = JOB_PASS;
    push_job.last = in_last;
    if (src_enc == dst_enc) begin
      partial_nxt = '0;
      pending_nxt = '0;
      emit        = 1'b1;
      case (src_enc)
        ENC_BYTE, ENC_UTF8: push_job.unit = {24'd0, in_unit[7:0]};
        ENC_UTF16:          push_job.unit = {16'd0, in_unit[15:0]};
        default:            push_job.unit = in_unit;
      endcase
    end else begin
      case (src_enc)
        ENC_BYTE: begin
          cp          = {24'd0, in_unit[7:0]};
          partial_nxt = '0;
          pending_nxt = '0;
          have        = 1'b1;
        end
        ENC_UTF8: begin
          if (pending_r != 2'd0) begin
            partial_nxt = cont8;
            pending_nxt = pending_r - 2'd1;
            if (pending_r == 2'd1) begin
              cp          = {11'd0, cont8};
              partial_nxt = '0;
              have        = 1'b1;
            end
          end else if (!in_unit[7]) begin
            cp   = {24'd0, in_unit[7:0]};
            have = 1'b1;
          end else if (in_unit[5]) begin
            if (in_unit[4]) begin
              partial_nxt = {18'd0, in_unit[2:0]};
              pending_nxt = 2'd3;
            end else begin
              partial_nxt = {17'd0, in_unit[3:0]};
              pending_nxt = 2'd2;
            end
          end else begin
            partial_nxt = {16'd0, in_unit[4:0]};
            pending_nxt = 2'd1;
          end
        end
        ENC_UTF16: begin
          if (pending_r != 2'd0) begin
            cp          = {11'd0, pair16};
            partial_nxt = '0;
            pending_nxt = '0;
            have        = 1'b1;
          end else if ((in_unit[15:0] & SURR_MASK) == SURR_HIGH) begin
            partial_nxt = {11'd0, in_unit[9:0]};
            pending_nxt = 2'd1;
          end else begin
            cp   = {16'd0, in_unit[15:0]};
            have = 1'b1;
          end
        end
        default: begin
          cp          = in_unit;
          partial_nxt = '0;
          pending_nxt = '0;
          have        = 1'b1;
        end
      endcase
      if (have) begin
        emit          = 1'b1;
        push_job.unit = cp;
        push_job.kind = JOB_ENC;
      end else if (in_last) begin
        partial_nxt   = '0;
        pending_nxt   = '0;
        emit          = 1'b1;
        push_job.kind = JOB_TRUNC;
        push_job.last = 1'b1;
      end
    end
  end

  assign push_valid = acc & emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      pending_r <= '0;
    end else if (acc) begin
      partial_r <= partial_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

[design/ttc_queue.sv]
// Short job queue between front and back end.
// Depends on ttc_pkg for the job type.
module ttc_queue #(
  parameter int DEPTH = ttc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ttc_pkg::job_t push_job,
  output logic          ready,
  input  logic          pop,
  output logic          head_valid,
  output ttc_pkg::job_t head_job
);
  import ttc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign ready      = (count_r != CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];
  assign do_push    = push & ready;
  assign do_pop     = pop & head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[design/ttc_back.sv]
// Back end: encodes queued jobs into target units, one word per cycle
// while out_tready is high, through an output register. Depends on ttc_pkg.
module ttc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  ttc_pkg::enc_t dst_enc,
  input  logic          head_valid,
  input  ttc_pkg::job_t head_job,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [31:0]   out_tdata,
  output logic          out_tlast,
  output logic          out_tuser
);
  import ttc_pkg::*;

  logic [3:0][31:0] units;
  logic [1:0]       last_idx;
  logic [1:0]       idx_r;
  logic [31:0]      cp;
  logic [31:0]      supp;
  logic             load;
  logic             final_unit;
  logic             valid_r;
  logic [31:0]      data_r;
  logic             last_r;
  logic             trunc_r;

  assign cp   = head_job.unit;
  assign supp = cp - SUPP_BASE;

  always_comb begin
    units    = '0;
    last_idx = 2'd0;
    case (head_job.kind)
      JOB_PASS:  units[0] = cp;
      JOB_TRUNC: units[0] = '0;
      default: begin
        case (dst_enc)
          ENC_BYTE: units[0] = (cp < 32'h100) ? cp : SUBST_CHAR;
          ENC_UTF8: begin
            if (cp > 32'hFFFF) begin
              units[0] = {24'd0, 5'b11110, cp[20:18]};
              units[1] = {24'd0, 2'b10, cp[17:12]};
              units[2] = {24'd0, 2'b10, cp[11:6]};
              units[3] = {24'd0, 2'b10, cp[5:0]};
              last_idx = 2'd3;
            end else if (cp > 32'h7FF) begin
              units[0] = {24'd0, 4'b1110, cp[15:12]};
              units[1] = {24'd0, 2'b10, cp[11:6]};
              units[2] = {24'd0, 2'b10, cp[5:0]};
              last_idx = 2'd2;
            end else if (cp > 32'h7F) begin
              units[0] = {24'd0, 3'b110, cp[10:6]};
              units[1] = {24'd0, 2'b10, cp[5:0]};
              last_idx = 2'd1;
            end else begin
              units[0] = cp;
            end
          end
          ENC_UTF16: begin
            if (cp > 32'hFFFF) begin
              units[0] = {16'd0, SURR_HIGH | {6'd0, supp[19:10]}};
              units[1] = {16'd0, SURR_LOW | {6'd0, supp[9:0]}};
              last_idx = 2'd1;
            end else begin
              units[0] = cp;
            end
          end
          default: units[0] = cp;
        endcase
      end
    endcase
  end

  assign load       = head_valid & (~valid_r | out_tready);
  assign final_unit = (idx_r == last_idx);
  assign pop        = load & final_unit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= final_unit ? 2'd0 : idx_r + 2'd1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r  <= units[idx_r];
      last_r  <= head_job.last & final_unit;
      trunc_r <= (head_job.kind == JOB_TRUNC);
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = trunc_r;

endmodule

[design/text_encoding_transcoder_top.sv]
// Transcoder between single-byte, UTF-8, UTF-16 and UTF-32 code units.
// Words pass through the job queue, then the output register. Throughput:
// one output word per cycle unless out_tready is low; one input word per
// cycle unless the output stalls or the encoder is busy emitting a
// multi-word sequence (up to 4). Reset (rst_n low, synchronous): queue
// and decoder state cleared; source encoding UTF-8, target UTF-16.
module text_encoding_transcoder_top #(
  parameter int QUEUE_DEPTH = ttc_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // [31:0] in_unit
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // [31:0] out_unit
  output logic                          out_tlast,
  output logic                          out_tuser,  // [0] truncated
  input  logic                          cfg_wen,
  input  logic [ttc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [1:0]                    cfg_wdata
);
  import ttc_pkg::*;

  enc_t src_enc_r, dst_enc_r;
  logic push_valid, q_ready, head_valid, pop;
  job_t push_job, head_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_enc_r <= SRC_RESET;
      dst_enc_r <= DST_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_SRC: src_enc_r <= enc_t'(cfg_wdata);
        CFG_DST: dst_enc_r <= enc_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign in_tready = q_ready;

  ttc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .src_enc    (src_enc_r),
    .dst_enc    (dst_enc_r),
    .in_valid   (in_tvalid),
    .in_unit    (in_tdata),
    .in_last    (in_tlast),
    .q_ready    (q_ready),
    .push_valid (push_valid),
    .push_job   (push_job)
  );

  ttc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_job   (push_job),
    .ready      (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  ttc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .dst_enc    (dst_enc_r),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

[design/ttc_checker.sv]
// Port-level checks for the transcoder top level, bound in below.
// No package dependency; watches the output handshake, input ready and reset.
module ttc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // truncation marker is a zero word closing the text
  a_trunc_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 32'd0 && out_tlast)
    else $error("truncation word malformed");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled output word changed");

endmodule

bind text_encoding_transcoder_top ttc_checker u_ttc_checker (.*);

[dv/text_encoding_transcoder_top_tb.sv]
// Self-checking testbench for text_encoding_transcoder_top: directed and random text
// streams across all source/target encoding pairs, checked against an in-bench decoder.
// Depends on ttc_pkg and the transcoder RTL only.
module text_encoding_transcoder_top_tb;
  import ttc_pkg::*;

  localparam int SETTLE_CYCLES   = 6;
  localparam int WORDS_PER_PHASE = 20;

  typedef struct {
    logic [31:0] data;
    logic        last;
    logic        trunc;
  } out_word_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata   = '0;   // [31:0] in_unit
  logic                 in_tlast   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b1;
  logic [31:0]          out_tdata;         // [31:0] out_unit
  logic                 out_tlast;
  logic                 out_tuser;         // [0] truncated
  logic                 cfg_wen    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [1:0]           cfg_wdata  = '0;

  out_word_t   expected_words[$];
  out_word_t   want;
  enc_t        cur_src  = SRC_RESET;
  enc_t        cur_dst  = DST_RESET;
  logic [20:0] acc_code = '0;
  logic [1:0]  acc_left = '0;
  bit          steady   = 1'b0;
  int          words_sent    = 0;
  int          words_checked = 0;
  int          mismatches    = 0;

  text_encoding_transcoder_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  task automatic expect_word(input logic [31:0] data, input logic last, input logic trunc);
    out_word_t w;
    w.data  = data;
    w.last  = last;
    w.trunc = trunc;
    expected_words.push_back(w);
  endtask

  task automatic encode_point(input logic [31:0] cp, input logic last);
    logic [31:0] s;
    case (cur_dst)
      ENC_BYTE: expect_word((cp < 32'h100) ? cp : SUBST_CHAR, last, 1'b0);
      ENC_UTF8: begin
        if (cp > 32'hFFFF) begin
          expect_word({24'h0, 5'b11110, cp[20:18]}, 1'b0, 1'b0);
          expect_word({24'h0, 2'b10, cp[17:12]}, 1'b0, 1'b0);
          expect_word({24'h0, 2'b10, cp[11:6]}, 1'b0, 1'b0);
          expect_word({24'h0, 2'b10, cp[5:0]}, last, 1'b0);
        end else if (cp > 32'h7FF) begin
          expect_word({24'h0, 4'b1110, cp[15:12]}, 1'b0, 1'b0);
          expect_word({24'h0, 2'b10, cp[11:6]}, 1'b0, 1'b0);
          expect_word({24'h0, 2'b10, cp[5:0]}, last, 1'b0);
        end else if (cp > 32'h7F) begin
          expect_word({24'h0, 3'b110, cp[10:6]}, 1'b0, 1'b0);
          expect_word({24'h0, 2'b10, cp[5:0]}, last, 1'b0);
        end else begin
          expect_word(cp, last, 1'b0);
        end
      end
      ENC_UTF16: begin
        if (cp > 32'hFFFF) begin
          s = cp - SUPP_BASE;
          expect_word({16'h0, SURR_HIGH | {6'h0, s[19:10]}}, 1'b0, 1'b0);
          expect_word({16'h0, SURR_LOW | {6'h0, s[9:0]}}, last, 1'b0);
        end else begin
          expect_word(cp, last, 1'b0);
        end
      end
      default: expect_word(cp, last, 1'b0);
    endcase
  endtask

  task automatic predict_unit(input logic [31:0] unit, input logic last);
    logic [31:0] cp;
    logic        have;
    logic [7:0]  b;
    logic [15:0] w;
    cp   = '0;
    have = 1'b0;
    b    = unit[7:0];
    w    = unit[15:0];
    if (cur_src == cur_dst) begin
      acc_code = '0;
      acc_left = '0;
      case (cur_src)
        ENC_BYTE, ENC_UTF8: expect_word({24'h0, b}, last, 1'b0);
        ENC_UTF16:          expect_word({16'h0, w}, last, 1'b0);
        default:            expect_word(unit, last, 1'b0);
      endcase
    end else begin
      case (cur_src)
        ENC_BYTE: begin
          cp = {24'h0, b};
          acc_code = '0;
          acc_left = '0;
          have = 1'b1;
        end
        ENC_UTF8: begin
          if (acc_left != 2'd0) begin
            acc_code = {acc_code[14:0], b[5:0]};
            acc_left = acc_left - 2'd1;
            if (acc_left == 2'd0) begin
              cp = {11'h0, acc_code};
              acc_code = '0;
              have = 1'b1;
            end
          end else if (!b[7]) begin
            cp = {24'h0, b};
            have = 1'b1;
          end else if (b[5]) begin
            if (b[4]) begin
              acc_code = {18'h0, b[2:0]};
              acc_left = 2'd3;
            end else begin
              acc_code = {17'h0, b[3:0]};
              acc_left = 2'd2;
            end
          end else begin
            acc_code = {16'h0, b[4:0]};
            acc_left = 2'd1;
          end
        end
        ENC_UTF16: begin
          if (acc_left != 2'd0) begin
            cp = {12'h0, acc_code[9:0], w[9:0]} + SUPP_BASE;
            acc_code = '0;
            acc_left = '0;
            have = 1'b1;
          end else if ((w & SURR_MASK) == SURR_HIGH) begin
            acc_code = {11'h0, w[9:0]};
            acc_left = 2'd1;
          end else begin
            cp = {16'h0, w};
            have = 1'b1;
          end
        end
        default: begin
          cp = unit;
          acc_code = '0;
          acc_left = '0;
          have = 1'b1;
        end
      endcase
      if (have) begin
        encode_point(cp, last);
      end else if (last) begin
        acc_code = '0;
        acc_left = '0;
        expect_word(32'h0, 1'b1, 1'b1);
      end
    end
  endtask

  // ---------------------------------------------------------------- drivers

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 27);
  end

  task automatic send_word(input logic [31:0] unit, input logic last);
    predict_unit(unit, last);
    while (!steady && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= unit;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // wait until every expected word is back and the decoder has gone quiet
  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_encodings(input enc_t src, input enc_t dst);
    drain();
    cfg_wen   <= 1'b1;
    cfg_index <= CFG_SRC;
    cfg_wdata <= src;
    @(posedge clk);
    cfg_index <= CFG_DST;
    cfg_wdata <= dst;
    @(posedge clk);
    cfg_wen <= 1'b0;
    cur_src = src;
    cur_dst = dst;
  endtask

  // ---------------------------------------------------------------- checker

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        note_mismatch($sformatf("unexpected word data=%h last=%b trunc=%b",
                                out_tdata, out_tlast, out_tuser));
      end else begin
        want = expected_words.pop_front();
        if (out_tdata !== want.data || out_tlast !== want.last || out_tuser !== want.trunc)
          note_mismatch($sformatf("exp data=%h last=%b trunc=%b, got data=%h last=%b trunc=%b",
                                  want.data, want.last, want.trunc,
                                  out_tdata, out_tlast, out_tuser));
      end
    end
  end

  // ---------------------------------------------------------------- random text

  function automatic logic [31:0] cont_byte(input logic [5:0] payload);
    logic [31:0] r;
    r = $urandom;
    return {r[31:8], ($urandom_range(7) == 0) ? r[7:6] : 2'b10, payload};
  endfunction

  function automatic logic [31:0] pick_code();
    case ($urandom_range(4))
      0:       return $urandom_range(32'h7F, 32'h0);
      1:       return $urandom_range(32'h7FF, 32'h80);
      2:       return $urandom_range(32'hFFFF, 32'h800);
      3:       return $urandom_range(32'h10FFFF, 32'h10000);
      default: return (cur_src == ENC_UTF16) ? $urandom_range(32'h10FFFF, 32'h10000)
                                             : $urandom_range(32'h1FFFFF, 32'h110000);
    endcase
  endfunction

  // encode one code point in the current source encoding; cut drops its tail
  task automatic send_char(input logic [31:0] cp, input logic last, input logic cut);
    logic [31:0] seq[4];
    logic [31:0] junk;
    logic [31:0] s;
    int          n;
    int          count;
    junk = $urandom;
    n    = 1;
    case (cur_src)
      ENC_BYTE: seq[0] = {junk[31:8], cp[7:0]};
      ENC_UTF8: begin
        if (cp < 32'h80) begin
          seq[0] = {junk[31:8], 1'b0, cp[6:0]};
        end else if (cp < 32'h800) begin
          seq[0] = {junk[31:8], 3'b110, cp[10:6]};
          seq[1] = cont_byte(cp[5:0]);
          n = 2;
        end else if (cp < 32'h10000) begin
          seq[0] = {junk[31:8], 4'b1110, cp[15:12]};
          seq[1] = cont_byte(cp[11:6]);
          seq[2] = cont_byte(cp[5:0]);
          n = 3;
        end else begin
          seq[0] = {junk[31:8], 5'b11110, cp[20:18]};
          seq[1] = cont_byte(cp[17:12]);
          seq[2] = cont_byte(cp[11:6]);
          seq[3] = cont_byte(cp[5:0]);
          n = 4;
        end
      end
      ENC_UTF16: begin
        if (cp > 32'hFFFF) begin
          s = cp - SUPP_BASE;
          seq[0] = {junk[31:16], 6'b110110, s[19:10]};
          seq[1] = {junk[15:0], ($urandom_range(7) == 0) ? junk[31:26] : 6'b110111, s[9:0]};
          n = 2;
        end else begin
          seq[0] = {junk[31:16], cp[15:0]};
        end
      end
      default: seq[0] = ($urandom_range(3) == 0) ? junk : cp;
    endcase
    count = (cut && n > 1) ? $urandom_range(n - 1, 1) : n;
    for (int k = 0; k < count; k++)
      send_word(seq[k], (k == count - 1) ? last : 1'b0);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_utf8_decode;
    // reset encodings: UTF-8 in, UTF-16 out
    send_word(32'hFFFF_FF00, 1'b0);
    send_word(32'h0000_007F, 1'b0);
    send_word(32'h0000_0085, 1'b0);   // odd two-byte lead, unchecked tag follows
    send_word(32'h0000_003F, 1'b0);
    send_word(32'h0000_00E2, 1'b0);
    send_word(32'h0000_0082, 1'b0);
    send_word(32'h0000_00AC, 1'b0);
    send_word(32'h0000_00B7, 1'b0);   // four-byte class, payload all ones
    send_word(32'h0000_00BF, 1'b0);
    send_word(32'h0000_00BF, 1'b0);
    send_word(32'h0000_00BF, 1'b0);
    send_word(32'h0000_00E2, 1'b1);   // text ends inside a sequence
  endtask

  task automatic test_utf16_decode;
    set_encodings(ENC_UTF16, ENC_UTF8);
    send_word(32'h0000_D83D, 1'b0);
    send_word(32'h0000_DE00, 1'b0);
    send_word(32'h0000_DC00, 1'b0);   // lone low surrogate
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_D800, 1'b0);   // low half taken whatever its tag
    send_word(32'h0000_0041, 1'b0);
    send_word(32'h0000_D800, 1'b1);
  endtask

  task automatic test_wide_and_byte;
    set_encodings(ENC_UTF32, ENC_BYTE);
    send_word(32'h0000_00FF, 1'b0);
    send_word(32'h0000_0100, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    set_encodings(ENC_UTF32, ENC_UTF8);
    send_word(32'hFFFF_FFFF, 1'b1);
    set_encodings(ENC_UTF32, ENC_UTF16);
    send_word(32'hFFFF_FFFF, 1'b0);
    set_encodings(ENC_BYTE, ENC_UTF32);
    send_word(32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_passthrough;
    for (int e = 0; e < 4; e++) begin
      set_encodings(enc_t'(e), enc_t'(e));
      send_word(32'hFFFF_FFFF, 1'b1);
    end
  endtask

  task automatic test_config_mid_sequence;
    set_encodings(ENC_UTF8, ENC_UTF32);
    send_word(32'h0000_00E2, 1'b0);
    set_encodings(ENC_UTF16, ENC_UTF32);   // pending lead finished as a low half
    send_word(32'h0000_1234, 1'b0);
    set_encodings(ENC_UTF8, ENC_UTF32);
    send_word(32'h0000_00F0, 1'b0);
    set_encodings(ENC_BYTE, ENC_UTF32);    // pending count dropped
    send_word(32'h0000_0041, 1'b0);
  endtask

  task automatic test_random_text;
    int goal;
    int r;
    bit paused;
    for (int p = 0; p < 16; p++) begin
      set_encodings(enc_t'(p / 4), enc_t'(p % 4));
      steady = (p == 5);
      paused = 1'b0;
      goal = words_sent + WORDS_PER_PHASE;
      while (words_sent < goal) begin
        r = $urandom_range(99);
        if (r < 75)
          send_char(pick_code(), $urandom_range(9) == 0, 1'b0);
        else if (r < 87)
          send_char(pick_code(), $urandom_range(1) == 1, 1'b1);
        else
          send_word($urandom, $urandom_range(3) == 0);
        if (p == 9 && !paused && words_sent >= goal - WORDS_PER_PHASE / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_utf8_decode();
    test_utf16_decode();
    test_wide_and_byte();
    test_passthrough();
    test_config_mid_sequence();
    test_random_text();
    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d source words across all 16 encoding pairs; %0d target words checked.",
             words_sent, words_checked);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/ttc_pkg.sv
design/ttc_front.sv
design/ttc_queue.sv
design/ttc_back.sv
design/text_encoding_transcoder_top.sv
design/ttc_checker.sv
dv/text_encoding_transcoder_top_tb.sv
